@@ hdl/msscan_pkg.sv @@
// Shared types and constants of the masked signature scanner.
`default_nettype none

package msscan_pkg;

  localparam int unsigned PATTERN_REG_BYTES = 16;

  localparam logic [3:0]  HIT_LIST_DEPTH = 4'd8;
  localparam logic [23:0] COUNT_MAX      = 24'hFF_FFFF;

  localparam logic [2:0] CFG_PATTERN_LOW    = 3'd0;
  localparam logic [2:0] CFG_PATTERN_HIGH   = 3'd1;
  localparam logic [2:0] CFG_CARE_MASK      = 3'd2;
  localparam logic [2:0] CFG_PATTERN_LENGTH = 3'd3;
  localparam logic [2:0] CFG_REGION_BASE    = 3'd4;
  localparam logic [2:0] CFG_PATCH_OFFSET   = 3'd5;
  localparam logic [2:0] CFG_HIT_LIMIT      = 3'd6;

  localparam logic [1:0] VERDICT_NOT_FOUND   = 2'd0;
  localparam logic [1:0] VERDICT_UNIQUE      = 2'd1;
  localparam logic [1:0] VERDICT_AMBIGUOUS   = 2'd2;
  localparam logic [1:0] VERDICT_UNAVAILABLE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic        is_summary;
    logic [31:0] hit_address;
    logic [2:0]  hit_number;
    logic [23:0] match_total;
    logic [1:0]  verdict;
    logic [31:0] resolved_address;
    logic        run_end;
  } out_word_t;

  typedef struct packed {
    logic [127:0]       pattern;
    logic [15:0]        care_mask;
    logic [4:0]         pattern_length;
    logic [31:0]        region_base;
    logic signed [15:0] patch_offset;
    logic [3:0]         hit_limit;
  } cfg_t;

  typedef struct packed {
    logic      hit_valid;
    out_word_t hit;
    logic      sum_valid;
    out_word_t sum;
  } pair_t;

endpackage

`default_nettype wire

@@ hdl/msscan_cfg.sv @@
// Configuration register file of the masked signature scanner.
`default_nettype none

module msscan_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  output msscan_pkg::cfg_t  cfg
);

  msscan_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pattern        <= '0;
      regs.care_mask      <= 16'hFFFF;
      regs.pattern_length <= '0;
      regs.region_base    <= '0;
      regs.patch_offset   <= '0;
      regs.hit_limit      <= msscan_pkg::HIT_LIST_DEPTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msscan_pkg::CFG_PATTERN_LOW:    regs.pattern[63:0]   <= cfg_data;
        msscan_pkg::CFG_PATTERN_HIGH:   regs.pattern[127:64] <= cfg_data;
        msscan_pkg::CFG_CARE_MASK:      regs.care_mask       <= cfg_data[15:0];
        msscan_pkg::CFG_PATTERN_LENGTH: regs.pattern_length  <= cfg_data[4:0];
        msscan_pkg::CFG_REGION_BASE:    regs.region_base     <= cfg_data[31:0];
        msscan_pkg::CFG_PATCH_OFFSET:   regs.patch_offset    <= cfg_data[15:0];
        msscan_pkg::CFG_HIT_LIMIT:      regs.hit_limit       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

@@ hdl/msscan_core.sv @@
// Input register, byte window, masked compare and scan counters.
`default_nettype none

module msscan_core #(
  parameter int PATTERN_BYTES = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire msscan_pkg::cfg_t     cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire msscan_pkg::in_word_t in_word,
  input  wire logic                 load_ok,
  output logic                      pair_load,
  output msscan_pkg::pair_t         pair
);

  localparam int LW = $clog2(PATTERN_BYTES + 1);
  localparam int IW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

  logic                 q_valid;
  msscan_pkg::in_word_t q_word;

  logic [7:0]               window      [PATTERN_BYTES];
  logic [7:0]               window_next [PATTERN_BYTES];
  logic [POSITION_BITS-1:0] bytes_seen;
  logic [POSITION_BITS-1:0] bytes_seen_next;
  logic [23:0]              match_count;
  logic [23:0]              match_count_next;
  logic [31:0]              first_hit;
  logic [31:0]              first_hit_next;

  logic [LW-1:0] eff_len;
  logic [IW-1:0] sel;
  logic [7:0]    pat_byte;
  logic          care;
  logic          mismatch;
  logic          match;
  logic [31:0]   addr;
  logic [3:0]    lim;
  logic          report;
  logic [1:0]    verdict;
  logic [23:0]   total;
  logic          advance;

  assign advance   = q_valid && load_ok;
  assign in_ready  = !q_valid || load_ok;
  assign pair_load = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_word <= in_word;
    end
  end

  always_comb begin
    window_next[0] = q_word.data_byte;
    for (int k = 1; k < PATTERN_BYTES; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign eff_len = (32'(cfg.pattern_length) > 32'(PATTERN_BYTES)) ?
                   LW'(PATTERN_BYTES) : LW'(cfg.pattern_length);

  always_comb begin
    mismatch = 1'b0;
    sel      = '0;
    pat_byte = '0;
    care     = 1'b1;
    for (int j = 0; j < PATTERN_BYTES; j++) begin
      if (j < msscan_pkg::PATTERN_REG_BYTES) begin
        pat_byte = cfg.pattern[8*(j % msscan_pkg::PATTERN_REG_BYTES) +: 8];
        care     = cfg.care_mask[j % msscan_pkg::PATTERN_REG_BYTES];
      end else begin
        pat_byte = '0;
        care     = 1'b1;
      end
      sel = IW'(32'(eff_len) - 32'(j) - 32'd1);
      if ((32'(j) < 32'(eff_len)) && care && (window_next[sel] != pat_byte)) begin
        mismatch = 1'b1;
      end
    end
  end

  assign bytes_seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + POSITION_BITS'(1);
  assign match = (eff_len != '0) && (32'(bytes_seen_next) >= 32'(eff_len)) && !mismatch;
  assign addr  = cfg.region_base + (32'(bytes_seen_next) - 32'(eff_len));

  assign match_count_next = (match && match_count != msscan_pkg::COUNT_MAX) ?
                            match_count + 24'd1 : match_count;
  assign first_hit_next   = (match && match_count == '0) ? addr : first_hit;

  assign lim    = (cfg.hit_limit > msscan_pkg::HIT_LIST_DEPTH) ?
                  msscan_pkg::HIT_LIST_DEPTH : cfg.hit_limit;
  assign report = match && (match_count < 24'(lim));

  always_comb begin
    if (eff_len == '0) begin
      verdict = msscan_pkg::VERDICT_UNAVAILABLE;
      total   = '0;
    end else begin
      total = match_count_next;
      priority if (match_count_next == 24'd0) begin
        verdict = msscan_pkg::VERDICT_NOT_FOUND;
      end else if (match_count_next == 24'd1) begin
        verdict = msscan_pkg::VERDICT_UNIQUE;
      end else begin
        verdict = msscan_pkg::VERDICT_AMBIGUOUS;
      end
    end
  end

  always_comb begin
    pair.hit_valid            = report;
    pair.hit.is_summary       = 1'b0;
    pair.hit.hit_address      = addr;
    pair.hit.hit_number       = match_count[2:0];
    pair.hit.match_total      = match_count_next;
    pair.hit.verdict          = msscan_pkg::VERDICT_NOT_FOUND;
    pair.hit.resolved_address = '0;
    pair.hit.run_end          = !q_word.final_byte;

    pair.sum_valid            = q_word.final_byte;
    pair.sum.is_summary       = 1'b1;
    pair.sum.hit_address      = '0;
    pair.sum.hit_number       = '0;
    pair.sum.match_total      = total;
    pair.sum.verdict          = verdict;
    pair.sum.resolved_address = (verdict == msscan_pkg::VERDICT_UNIQUE) ?
        first_hit_next + {{16{cfg.patch_offset[15]}}, cfg.patch_offset} : 32'd0;
    pair.sum.run_end          = 1'b1;
  end

  // Window bytes older than bytes_seen are never compared, so no clear is needed.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < PATTERN_BYTES; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen  <= '0;
      match_count <= '0;
      first_hit   <= '0;
    end else if (advance) begin
      if (q_word.final_byte) begin
        bytes_seen  <= '0;
        match_count <= '0;
        first_hit   <= '0;
      end else begin
        bytes_seen  <= bytes_seen_next;
        match_count <= match_count_next;
        first_hit   <= first_hit_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/msscan_out.sv @@
// Result register: holds a hit report and a summary and sends them in order.
`default_nettype none

module msscan_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pair_load,
  input  wire msscan_pkg::pair_t pair,
  output logic                   load_ok,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output msscan_pkg::out_word_t  out_word
);

  logic                  hit_v;
  logic                  sum_v;
  msscan_pkg::out_word_t hit_q;
  msscan_pkg::out_word_t sum_q;
  logic                  take;

  assign out_valid = hit_v || sum_v;
  assign out_word  = hit_v ? hit_q : sum_q;
  assign take      = out_valid && out_ready;
  assign load_ok   = !out_valid || (out_ready && !(hit_v && sum_v));

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_v <= 1'b0;
      sum_v <= 1'b0;
    end else if (pair_load) begin
      hit_v <= pair.hit_valid;
      sum_v <= pair.sum_valid;
    end else if (take) begin
      if (hit_v) begin
        hit_v <= 1'b0;
      end else begin
        sum_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_load) begin
      hit_q <= pair.hit;
      sum_q <= pair.sum;
    end
  end

endmodule

`default_nettype wire

@@ hdl/masked_signature_scanner.sv @@
// Top level of the masked signature scanner.
// Takes one region byte per cycle while in_ready is high and compares the newest
// pattern_length bytes with a masked pattern; each byte passes an input register
// and then the result register. The sustained rate is one byte per cycle while
// the output is not stalled. A final byte that also completes a reported hit
// yields two words, hit then summary, which leave the result register in turn;
// the next byte waits for the second. Write configuration only while idle.
`default_nettype none

module masked_signature_scanner #(
  parameter int PATTERN_BYTES = 16,
  parameter int POSITION_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire msscan_pkg::in_word_t in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output msscan_pkg::out_word_t     out_word
);

  msscan_pkg::cfg_t  cfg;
  msscan_pkg::pair_t pair;
  logic              pair_load;
  logic              load_ok;

  msscan_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msscan_core #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .load_ok   (load_ok),
    .pair_load (pair_load),
    .pair      (pair)
  );

  msscan_out u_out (
    .clk       (clk),
    .rst       (rst),
    .pair_load (pair_load),
    .pair      (pair),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

@@ hdl/msscan_checker.sv @@
// Port-level assertions of the masked signature scanner, bound to the top level.
`default_nettype none

module msscan_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire msscan_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word dropped or changed while stalled");

  a_summary_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.is_summary |-> out_word.run_end &&
      out_word.hit_address == 32'd0 && out_word.hit_number == 3'd0)
    else $error("malformed summary word");

  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.is_summary |->
      out_word.verdict == msscan_pkg::VERDICT_NOT_FOUND &&
      out_word.resolved_address == 32'd0 && out_word.match_total != 24'd0)
    else $error("malformed hit word");

  a_verdict_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.is_summary |->
      ((out_word.verdict == msscan_pkg::VERDICT_NOT_FOUND ||
        out_word.verdict == msscan_pkg::VERDICT_UNAVAILABLE) ==
       (out_word.match_total == 24'd0)) &&
      ((out_word.verdict == msscan_pkg::VERDICT_UNIQUE) ==
       (out_word.match_total == 24'd1)))
    else $error("verdict disagrees with match total");

  a_hit_then_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_word.is_summary && !out_word.run_end |=>
      out_valid && out_word.is_summary)
    else $error("summary does not follow hit on final word");

endmodule

bind masked_signature_scanner msscan_checker u_msscan_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
